### rtl/hst_pkg.sv
// package for the hop receiver sync tracker: constants, types and crc function
`timescale 1ns / 1ps

package hst_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MIN_GAP   = 2'd0,
        REG_MAX_GAP   = 2'd1,
        REG_FAIL_THR  = 2'd2,
        REG_UNUSED    = 2'd3
    } cfg_reg_t;

    // item kinds carried in tuser
    typedef enum logic {
        KIND_TICK   = 1'b0,
        KIND_PACKET = 1'b1
    } item_kind_t;

    localparam int unsigned PKT_BYTES    = 8;
    localparam int unsigned IN_DATA_W    = 64;
    localparam int unsigned OUT_FIELDS_W = 133;
    localparam int unsigned OUT_DATA_W   = 136;
    localparam int unsigned OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    localparam logic [7:0]  MIN_GAP_RESET  = 8'd21;
    localparam logic [7:0]  MAX_GAP_RESET  = 8'd27;
    localparam logic [7:0]  FAIL_THR_RESET = 8'd5;
    localparam logic [15:0] CRC_POLY       = 16'h1021;

    typedef logic [PKT_BYTES-1:0][7:0] pkt_bytes_t;

    // one byte of crc-16-ccitt, msb first, init and final xor handled by caller
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

### rtl/hop_receiver_sync_tracker_core.sv
// top level of the hop receiver sync tracker
`timescale 1ns / 1ps

// Hop receiver sync tracker.
// Input channel (s_*): one transaction per 100 ms tick (s_tuser = 0) or per
// received eight-byte packet (s_tuser = 1, bytes in s_tdata, byte 0 lowest).
// Output channel (m_*): exactly one result transaction per input transaction,
// in order, carrying hop and channel-zero requests, packet and crc flags, the
// sync flag and four wrapping 32-bit totals.
// Configuration: cfg_wr_en, cfg_addr and cfg_wdata write the minimum gap,
// maximum gap and fail threshold; write them only while the block is idle.
// An item is held in the input register and then in the result register,
// which drives m_tvalid. The tracker state and the parallel crc over
// CRC_BYTES bytes update as an item moves from the input register to the
// result register, so one item per cycle is sustained while m_tready stays
// high. When the receiver stalls, the result register holds; with the input
// register full, s_tready follows m_tready in the same cycle, and an empty
// input register takes one more transaction before s_tready drops.
// Reset clears both registers, puts the tracker out of sync, zeroes all
// counters and loads the register defaults 21, 27 and 5.
module hop_receiver_sync_tracker_core #(
    parameter int CRC_BYTES = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // header_byte, payload_one .. payload_five,
                                    // check_high, check_low (8 bits each)
    input  logic [0:0]   s_tuser,   // req_type
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // hop_request, go_channel_zero, packet_taken,
                                    // crc_good, in_sync, received_total,
                                    // missed_total, crc_error_total,
                                    // good_streak, 3 zero bits
    // configuration
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [7:0]   cfg_wdata
);
    import hst_pkg::*;

    // configuration registers
    logic [7:0] min_gap_reg, max_gap_reg, fail_thr_reg;

    // input register
    logic       in_valid_reg;
    item_kind_t in_kind_reg;
    pkt_bytes_t in_bytes_reg;

    // tracker state
    logic [7:0]  gap_reg, gap_next;
    logic        sync_lost_reg, sync_lost_next;
    logic [7:0]  miss_run_reg, miss_run_next;
    logic [31:0] received_reg, received_next;
    logic [31:0] missed_reg, missed_next;
    logic [31:0] crc_err_reg, crc_err_next;
    logic [31:0] streak_reg, streak_next;

    // result register
    logic        out_valid_reg;
    logic        hop_reg, hop_next;
    logic        zero_reg, zero_next;
    logic        taken_reg, taken_next;
    logic        good_reg, good_next;

    logic        advance;
    logic [15:0] crc_calc;
    logic [15:0] crc_rx;
    logic        crc_ok;
    logic [7:0]  gap_inc;
    logic [7:0]  miss_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg  <= MIN_GAP_RESET;
            max_gap_reg  <= MAX_GAP_RESET;
            fail_thr_reg <= FAIL_THR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_MIN_GAP:  min_gap_reg  <= cfg_wdata;
                REG_MAX_GAP:  max_gap_reg  <= cfg_wdata;
                REG_FAIL_THR: fail_thr_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg  <= item_kind_t'(s_tuser[0]);
            in_bytes_reg <= pkt_bytes_t'(s_tdata);
        end
    end

    // parallel crc over the leading packet bytes
    always_comb
    begin
        logic [15:0] crc;
        crc = 16'h0000;
        for (int i = 0; i < CRC_BYTES; i++)
            crc = crc_byte(crc, in_bytes_reg[i[2:0]]);
        crc_calc = crc;
    end

    assign crc_rx   = {in_bytes_reg[6], in_bytes_reg[7]};
    assign crc_ok   = (crc_calc == crc_rx) && (crc_calc != 16'h0000);
    assign gap_inc  = sync_lost_reg ? gap_reg : gap_reg + 8'd1;
    assign miss_inc = miss_run_reg + 8'd1;

    // tracker next state and result flags
    always_comb
    begin
        gap_next       = gap_reg;
        sync_lost_next = sync_lost_reg;
        miss_run_next  = miss_run_reg;
        received_next  = received_reg;
        missed_next    = missed_reg;
        crc_err_next   = crc_err_reg;
        streak_next    = streak_reg;
        hop_next       = 1'b0;
        zero_next      = 1'b0;
        taken_next     = 1'b0;
        good_next      = 1'b0;
        case (in_kind_reg)
            KIND_TICK:
            begin
                gap_next = gap_inc;
                if (gap_inc > max_gap_reg)
                begin
                    gap_next      = 8'd0;
                    miss_run_next = miss_inc;
                    missed_next   = missed_reg + 32'd1;
                    streak_next   = 32'd0;
                    if (miss_inc == fail_thr_reg)
                    begin
                        zero_next      = 1'b1;
                        sync_lost_next = 1'b1;
                    end
                    hop_next = !sync_lost_next;
                end
            end
            KIND_PACKET:
            begin
                // early in-sync packets are dropped without touching state
                if (sync_lost_reg || gap_reg >= min_gap_reg)
                begin
                    taken_next     = 1'b1;
                    hop_next       = 1'b1;
                    received_next  = received_reg + 32'd1;
                    gap_next       = 8'd0;
                    sync_lost_next = 1'b0;
                    miss_run_next  = 8'd0;
                    if (crc_ok)
                    begin
                        good_next   = 1'b1;
                        streak_next = streak_reg + 32'd1;
                    end
                    else
                    begin
                        crc_err_next = crc_err_reg + 32'd1;
                        streak_next  = 32'd0;
                    end
                end
            end
            default: ;
        endcase
    end

    // tracker state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg       <= 8'd0;
            sync_lost_reg <= 1'b1;
            miss_run_reg  <= 8'd0;
            received_reg  <= 32'd0;
            missed_reg    <= 32'd0;
            crc_err_reg   <= 32'd0;
            streak_reg    <= 32'd0;
        end
        else if (advance)
        begin
            gap_reg       <= gap_next;
            sync_lost_reg <= sync_lost_next;
            miss_run_reg  <= miss_run_next;
            received_reg  <= received_next;
            missed_reg    <= missed_next;
            crc_err_reg   <= crc_err_next;
            streak_reg    <= streak_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // result register flags
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hop_reg   <= hop_next;
            zero_reg  <= zero_next;
            taken_reg <= taken_next;
            good_reg  <= good_next;
        end
    end

    // totals always match the state left by the latest result
    assign m_tdata = {{OUT_PAD_W{1'b0}}, streak_reg, crc_err_reg, missed_reg,
                      received_reg, !sync_lost_reg, good_reg, taken_reg,
                      zero_reg, hop_reg};

    // checks
    a_zero_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(zero_reg && taken_reg))
        else $error("channel zero request on a packet result");

    a_good_needs_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!good_reg || taken_reg))
        else $error("crc good on a packet that was not taken");

    a_taken_clears_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && taken_next) |=> (gap_reg == 8'd0 && !sync_lost_reg
                                     && miss_run_reg == 8'd0))
        else $error("taken packet did not resync the tracker");

    a_zero_drops_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && zero_reg) |-> (sync_lost_reg && !hop_reg))
        else $error("channel zero request while still in sync");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(received_reg)
                                          && $stable(missed_reg)))
        else $error("result changed while the receiver stalled");

endmodule
